// ===== sv/icg_pkg.sv =====
`default_nettype none

package icg_pkg;

    // Field widths fixed by the interface.
    localparam int GRAD_W    = 24;
    localparam int AXIS_W    = 2;
    localparam int AREA_W    = 24;
    localparam int ICV_W     = 24;
    localparam int EPS_W     = 12;
    localparam int SUM_W     = 48;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    // Internal datapath widths.
    // Sum of two gradients, in half-LSB units.
    localparam int S_W    = GRAD_W + 1;
    // Sum of up to three squares, rounded up to an even width for the root.
    localparam int SQ_W   = 2 * S_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    // Root plus twice the epsilon.
    localparam int D_W    = ROOT_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INV_VOLUME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 1'd1;

    // Register reset values.
    localparam logic [ICV_W-1:0] ICV_RESET = 24'd4096;
    localparam logic [EPS_W-1:0] EPS_RESET = 12'd1;

    typedef logic signed [S_W-1:0] gsum_t;

endpackage

`default_nettype wire

// ===== sv/icg_sqrt.sv =====
`default_nettype none

module icg_sqrt #(
    parameter int RAD_W = 52
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic [RAD_W/2-1:0] root,
    output logic               done
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // One root bit per cycle: bring down two radicand bits and try 4r+1.
    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/icg_div.sv =====
`default_nettype none

module icg_div #(
    parameter int DEN_W = 27,
    parameter int Q_W   = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot,
    output logic             done
);

    // The numerator is num * 2^(Q_W-1); num must stay below twice den.
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

    logic [DEN_W:0]   rem_reg,  rem_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             run_reg,  run_next;
    logic             first_reg, first_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   cand;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        cand       = first_reg ? rem_reg : {rem_reg[DEN_W-1:0], 1'b0};
        rem_next   = rem_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = {1'b0, num};
            den_next   = den;
            quot_next  = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
            first_next = 1'b1;
        end
        else if (run_reg)
        begin
            first_next = 1'b0;
            if (cand >= {1'b0, den_reg})
            begin
                rem_next  = cand - {1'b0, den_reg};
                quot_next = {quot_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cand;
                quot_next = {quot_reg[Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/icg_mul.sv =====
`default_nettype none

module icg_mul #(
    parameter int A_W = 24,
    parameter int B_W = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] prod,
    output logic               done
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(B_W - 1);

    logic [P_W-1:0]   a_reg,   a_next;
    logic [B_W-1:0]   b_reg,   b_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    // Shift-add, one multiplier bit per cycle from the low end.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = P_W'(a);
            b_next   = b;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[P_W-2:0], 1'b0};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/interface_curvature_from_gradients_core.sv =====
`default_nettype none

// Channel   Handshake                 Word
// --------  ------------------------  -------------------------------------------
// config    cfg_wr_en                 cfg_index, cfg_data (no wait, no read-back)
// input     in_valid / in_ready       face_axis .. last_face, one cell face
// output    out_valid / out_ready     curvature, saturated (after last_face only)
//
// A face is accepted, squared, then passed through the square root, the division and the
// area product in turn; the bit-serial root is the longest of these steps. A last face
// then goes on to the volume product and to loading the output word.
// A face with an axis out of range skips the root, division and area product.
// Reset loads the register defaults and clears the face sum.
// One result word is held while the next face is taken; a stalled output stops the
// block only when a second result is ready.

module interface_curvature_from_gradients_core #(
    parameter int DIMENSION     = 3,
    parameter int FRACTION_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [icg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [icg_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [icg_pkg::AXIS_W-1:0]          face_axis,
    input  logic                                upper_face,
    input  logic signed [icg_pkg::GRAD_W-1:0]   centre_grad_x,
    input  logic signed [icg_pkg::GRAD_W-1:0]   centre_grad_y,
    input  logic signed [icg_pkg::GRAD_W-1:0]   centre_grad_z,
    input  logic signed [icg_pkg::GRAD_W-1:0]   neighbour_grad_x,
    input  logic signed [icg_pkg::GRAD_W-1:0]   neighbour_grad_y,
    input  logic signed [icg_pkg::GRAD_W-1:0]   neighbour_grad_z,
    input  logic [icg_pkg::AREA_W-1:0]          face_area,
    input  logic                                last_face,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [icg_pkg::OUT_W-1:0]    curvature,
    output logic                                saturated
);

    import icg_pkg::*;

    localparam int Q_W    = FRACTION_BITS + 1;
    localparam int AP_W   = AREA_W + Q_W;
    localparam int VP_W   = SUM_W + ICV_W;
    localparam int VQ_W   = VP_W - FRACTION_BITS;
    localparam logic [1:0] DIM_IDX = 2'(DIMENSION);
    localparam logic [Q_W-1:0] N_MAX = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [VQ_W-1:0] LIM_POS = VQ_W'(33'h07FFFFFFF);
    localparam logic [VQ_W-1:0] LIM_NEG = VQ_W'(33'h080000000);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_AMUL = 3'd4;
    localparam logic [2:0] ST_VMUL = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]          state_reg,   state_next;
    logic [1:0]          idx_reg,     idx_next;
    gsum_t               s0_reg,      s0_next;
    gsum_t               s1_reg,      s1_next;
    gsum_t               s2_reg,      s2_next;
    logic [AXIS_W-1:0]   axis_reg,    axis_next;
    logic                upper_reg,   upper_next;
    logic                last_reg,    last_next;
    logic [AREA_W-1:0]   area_reg,    area_next;
    logic [2*S_W-1:0]    sqp_reg,     sqp_next;
    logic [SQ_W-1:0]     sqacc_reg,   sqacc_next;
    logic [D_W-1:0]      d_reg,       d_next;
    logic [SUM_W-1:0]    sum_reg,     sum_next;
    logic [ICV_W-1:0]    icv_reg,     icv_next;
    logic [EPS_W-1:0]    eps_reg,     eps_next;
    logic                sqrt_go_reg, sqrt_go_next;
    logic                div_go_reg,  div_go_next;
    logic                amul_go_reg, amul_go_next;
    logic                vmul_go_reg, vmul_go_next;
    logic                ovalid_reg,  ovalid_next;
    logic [OUT_W-1:0]    curv_reg,    curv_next;
    logic                sat_reg,     sat_next;

    gsum_t               s_sel;
    gsum_t               s_axis;
    logic signed [2*S_W-1:0] sq_val;
    logic                axis_ok;
    logic                a_neg;
    logic [S_W-1:0]      a_mag;
    logic                sub_term;
    logic [SUM_W-1:0]    term;
    logic                sum_neg;
    logic                res_neg;
    logic [SUM_W-1:0]    sum_mag;
    logic [VQ_W-1:0]     vq;
    logic [VQ_W-1:0]     lim;
    logic                clip;
    logic [OUT_W-1:0]    qv;

    logic [ROOT_W-1:0]   root;
    logic                sqrt_done;
    logic [Q_W-1:0]      div_quot;
    logic                div_done;
    logic [Q_W-1:0]      n_val;
    logic [AP_W-1:0]     amul_prod;
    logic                amul_done;
    logic [VP_W-1:0]     vmul_prod;
    logic                vmul_done;

    // Operand selection and sign handling.
    always_comb
    begin
        s_sel    = (idx_reg == 2'd0) ? s0_reg : ((idx_reg == 2'd1) ? s1_reg : s2_reg);
        sq_val   = s_sel * s_sel;
        axis_ok  = (axis_reg < 2'd3) && (axis_reg < DIM_IDX);
        s_axis   = (axis_reg == 2'd0) ? s0_reg : ((axis_reg == 2'd1) ? s1_reg : s2_reg);
        a_neg    = s_axis[S_W-1];
        a_mag    = a_neg ? (~s_axis + 1'b1) : s_axis;
        sub_term = a_neg ^ ~upper_reg;
        n_val    = (d_reg == '0) ? '0 : div_quot;
        term     = SUM_W'(amul_prod[AP_W-1:FRACTION_BITS]);
        sum_neg  = sum_reg[SUM_W-1];
        res_neg  = !sum_neg && (sum_reg != '0);
        sum_mag  = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
        vq       = vmul_prod[VP_W-1:FRACTION_BITS];
        lim      = res_neg ? LIM_NEG : LIM_POS;
        clip     = vq > lim;
        qv       = clip ? lim[OUT_W-1:0] : vq[OUT_W-1:0];
    end

    // Face sequencer and configuration registers.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        axis_next    = axis_reg;
        upper_next   = upper_reg;
        last_next    = last_reg;
        area_next    = area_reg;
        sqp_next     = sqp_reg;
        sqacc_next   = sqacc_reg;
        d_next       = d_reg;
        sum_next     = sum_reg;
        icv_next     = icv_reg;
        eps_next     = eps_reg;
        sqrt_go_next = 1'b0;
        div_go_next  = 1'b0;
        amul_go_next = 1'b0;
        vmul_go_next = 1'b0;
        ovalid_next  = ovalid_reg;
        curv_next    = curv_reg;
        sat_next     = sat_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INV_VOLUME: icv_next = cfg_data[ICV_W-1:0];
                CFG_EPSILON:    eps_next = cfg_data[EPS_W-1:0];
                default:        ;
            endcase
        end

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    s0_next    = {centre_grad_x[GRAD_W-1], centre_grad_x}
                               + {neighbour_grad_x[GRAD_W-1], neighbour_grad_x};
                    s1_next    = {centre_grad_y[GRAD_W-1], centre_grad_y}
                               + {neighbour_grad_y[GRAD_W-1], neighbour_grad_y};
                    s2_next    = {centre_grad_z[GRAD_W-1], centre_grad_z}
                               + {neighbour_grad_z[GRAD_W-1], neighbour_grad_z};
                    axis_next  = face_axis;
                    upper_next = upper_face;
                    last_next  = last_face;
                    area_next  = face_area;
                    idx_next   = '0;
                    sqacc_next = '0;
                    state_next = ST_SQR;
                end
            end
            // One square per cycle, accumulated from its register in the next cycle.
            ST_SQR:
            begin
                sqp_next = sq_val;
                if (idx_reg != 2'd0)
                begin
                    sqacc_next = sqacc_reg + SQ_W'(sqp_reg);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == DIM_IDX)
                begin
                    if (axis_ok)
                    begin
                        sqrt_go_next = 1'b1;
                        state_next   = ST_ROOT;
                    end
                    else if (last_reg)
                    begin
                        vmul_go_next = 1'b1;
                        state_next   = ST_VMUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    d_next      = D_W'(root) + D_W'({eps_reg, 1'b0});
                    div_go_next = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    amul_go_next = 1'b1;
                    state_next   = ST_AMUL;
                end
            end
            // Fold the face term into the running sum.
            ST_AMUL:
            begin
                if (amul_done)
                begin
                    sum_next = sub_term ? (sum_reg - term) : (sum_reg + term);
                    if (last_reg)
                    begin
                        vmul_go_next = 1'b1;
                        state_next   = ST_VMUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_VMUL:
            begin
                if (vmul_done)
                begin
                    state_next = ST_OUT;
                end
            end
            // Clip, negate and hand the word to the output register.
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    curv_next   = res_neg ? (~qv + 1'b1) : qv;
                    sat_next    = clip;
                    ovalid_next = 1'b1;
                    sum_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            sum_reg     <= '0;
            icv_reg     <= ICV_RESET;
            eps_reg     <= EPS_RESET;
            sqrt_go_reg <= 1'b0;
            div_go_reg  <= 1'b0;
            amul_go_reg <= 1'b0;
            vmul_go_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            icv_reg     <= icv_next;
            eps_reg     <= eps_next;
            sqrt_go_reg <= sqrt_go_next;
            div_go_reg  <= div_go_next;
            amul_go_reg <= amul_go_next;
            vmul_go_reg <= vmul_go_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg    <= s0_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        axis_reg  <= axis_next;
        upper_reg <= upper_next;
        last_reg  <= last_next;
        area_reg  <= area_next;
        sqp_reg   <= sqp_next;
        sqacc_reg <= sqacc_next;
        d_reg     <= d_next;
        curv_reg  <= curv_next;
        sat_reg   <= sat_next;
    end

    // Serial units.
    icg_sqrt #(
        .RAD_W (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_go_reg),
        .radicand (sqacc_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    icg_div #(
        .DEN_W (D_W),
        .Q_W   (Q_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (D_W'(a_mag)),
        .den   (d_reg),
        .quot  (div_quot),
        .done  (div_done)
    );

    icg_mul #(
        .A_W (AREA_W),
        .B_W (Q_W)
    ) u_area_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (amul_go_reg),
        .a     (area_reg),
        .b     (n_val),
        .prod  (amul_prod),
        .done  (amul_done)
    );

    icg_mul #(
        .A_W (SUM_W),
        .B_W (ICV_W)
    ) u_vol_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (vmul_go_reg),
        .a     (sum_mag),
        .b     (icv_reg),
        .prod  (vmul_prod),
        .done  (vmul_done)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign curvature = curv_reg;
    assign saturated = sat_reg;

    // The unit normal component never exceeds one.
    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done && (d_reg != '0)) |-> (div_quot <= N_MAX))
        else $error("normal component exceeds one");

    // The root finishes only while the sequencer waits for it.
    a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_ROOT))
        else $error("square root finished out of sequence");

    // Emitting a result clears the face sum.
    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && (!ovalid_reg || out_ready)) |=> (sum_reg == '0))
        else $error("face sum not cleared after result");

    // An accepted face starts the squaring pass.
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ((state_reg == ST_SQR) && (idx_reg == 2'd0)))
        else $error("accepted face did not start squaring");

endmodule

`default_nettype wire
